// ===== rtl/core/nstg_pkg.sv =====
// nstg_pkg: shared types and constants for the note sequencer tone generator
// no dependencies; used by the interfaces and the core
`timescale 1ns / 1ps

package nstg_pkg;

  // default geometry
  localparam int unsigned StoreDepthDefault    = 256;
  localparam int unsigned PrescaleStepsDefault = 256;

  // field widths
  localparam int unsigned OpcodeW   = 2;
  localparam int unsigned EntryAddrW = 8;
  localparam int unsigned NoteW     = 16;
  localparam int unsigned PositionW = 8;
  localparam int unsigned BeatW     = 16;

  // configuration port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic [ApbAddrW-1:0] RegBeatLimitAddr = 3'h0;
  localparam logic [BeatW-1:0]    BeatLimitReset   = 16'd1240;

  // note codes with a meaning of their own
  localparam logic [NoteW-1:0] CodeHalt   = 16'd0;
  localparam logic [NoteW-1:0] CodeRepeat = 16'd1;
  localparam logic [NoteW-1:0] CodeRest   = 16'd2;
  localparam logic [NoteW-1:0] CodeHaltAlt = 16'd3;

  typedef enum logic [OpcodeW-1:0] {
    OpTick  = 2'd0,
    OpWrite = 2'd1,
    OpStart = 2'd2
  } op_e;

endpackage

// ===== rtl/core/nstg_if.sv =====
// nstg_if: valid/ready channels for input and result words
// depends on nstg_pkg for field widths
`timescale 1ns / 1ps

interface nstg_in_if;
  import nstg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OpcodeW-1:0]    opcode;
  logic [EntryAddrW-1:0] entry_address;
  logic [NoteW-1:0]      entry_value;

  modport source (output valid, output opcode, output entry_address, output entry_value,
                  input ready);
  modport sink   (input valid, input opcode, input entry_address, input entry_value,
                  output ready);
endinterface

interface nstg_out_if;
  import nstg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 speaker_level;
  logic                 speaker_driven;
  logic [PositionW-1:0] note_position;
  logic                 halted;

  modport source (output valid, output speaker_level, output speaker_driven,
                  output note_position, output halted, input ready);
  modport sink   (input valid, input speaker_level, input speaker_driven,
                  input note_position, input halted, output ready);
endinterface

// ===== rtl/core/nstg_ram.sv =====
// nstg_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module nstg_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/note_sequencer_tone_generator_core.sv =====
// note_sequencer_tone_generator_core: square wave melody sequencer top level
// depends on nstg_pkg, nstg_in_if / nstg_out_if and nstg_ram
// timing: a result word is registered in the cycle after its accepted word, or after the
//   note ram read register when the word reads a note; one word per cycle while the output
//   is free; input held off after a word that reads a note (every start, one tick per note)
// reset: asynchronous, active low; playback halted, counters cleared, beat_limit 1240;
//   note store contents undefined until written, no clearing pass
`timescale 1ns / 1ps

module note_sequencer_tone_generator_core #(
  parameter int unsigned StoreDepth    = nstg_pkg::StoreDepthDefault,
  parameter int unsigned PrescaleSteps = nstg_pkg::PrescaleStepsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  nstg_in_if.sink                        in_i,
  nstg_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nstg_pkg::ApbAddrW-1:0]  paddr,
  input  logic [nstg_pkg::ApbDataW-1:0]  pwdata,
  output logic [nstg_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import nstg_pkg::*;

  localparam int unsigned IdxW  = $clog2(StoreDepth);
  localparam int unsigned PresW = $clog2(PrescaleSteps);
  localparam logic [IdxW-1:0]  IdxLast  = IdxW'(StoreDepth - 1);
  localparam logic [PresW-1:0] PresLast = PresW'(PrescaleSteps - 1);

  // ---------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------
  logic [BeatW-1:0] beat_limit_q;
  logic             cfg_we;

  // byte offset bits ignored, anything above the register list is read as zero
  assign cfg_we = psel && penable && pwrite && (paddr[ApbAddrW-1:2] == RegBeatLimitAddr[ApbAddrW-1:2]);
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[ApbAddrW-1:2] == RegBeatLimitAddr[ApbAddrW-1:2]) begin
      prdata = ApbDataW'(beat_limit_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_limit_q <= BeatLimitReset;
    end else if (cfg_we) begin
      beat_limit_q <= pwdata[BeatW-1:0];
    end
  end

  // ---------------------------------------------------------------
  // playback state
  // ---------------------------------------------------------------
  logic [IdxW-1:0]  note_index_q, note_index_d;
  logic [NoteW-1:0] tone_period_q, tone_period_d;
  logic [NoteW-1:0] tone_count_q, tone_count_d;
  logic             wave_q, wave_d;
  logic [PresW-1:0] presc_q, presc_d;
  logic [BeatW-1:0] beat_q, beat_d;
  logic             drive_q, drive_d;
  logic             stopped_q, stopped_d;

  // copy of store entry 0, used by the repeat code so that it needs no second read
  logic [NoteW-1:0] entry0_q, entry0_d;

  // a note read is in flight: its data is held in the ram read register
  logic             pending_q, pending_d;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic                 out_level_q, out_driven_q, out_halted_q;
  logic [PositionW-1:0] out_pos_q;

  // handshake
  logic fire;
  logic out_free;
  logic out_load;
  op_e  op;

  // ram port
  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_waddr, ram_raddr;
  logic [NoteW-1:0] ram_rdata;
  logic             addr_ok;
  logic             rd_req;

  assign op       = op_e'(in_i.opcode);
  assign out_free = !out_valid_q || out_o.ready;
  // no new word while a note read resolves: the next tick needs its period and halt flag
  assign in_i.ready = !pending_q && out_free;
  assign fire     = in_i.valid && in_i.ready;

  // writes beyond the store depth are dropped
  assign addr_ok   = {24'b0, in_i.entry_address} < 32'(StoreDepth);
  assign ram_waddr = IdxW'(in_i.entry_address);
  assign ram_we    = fire && (op == OpWrite) && addr_ok;
  assign ram_re    = fire && rd_req;
  // start plays from the top of the store
  assign ram_raddr = (op == OpStart) ? '0 : note_index_q;

  nstg_ram #(
    .Width (NoteW),
    .Depth (StoreDepth)
  ) u_note_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.entry_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------
  // next state: accepted word first, then the resolution of a pending note read
  // (the two never coincide, the input is held off while a read is pending)
  // ---------------------------------------------------------------
  always_comb begin
    note_index_d  = note_index_q;
    tone_period_d = tone_period_q;
    tone_count_d  = tone_count_q;
    wave_d        = wave_q;
    presc_d       = presc_q;
    beat_d        = beat_q;
    drive_d       = drive_q;
    stopped_d     = stopped_q;
    entry0_d      = entry0_q;
    rd_req        = 1'b0;

    if (fire) begin
      unique case (op)
        OpTick: begin
          if (!stopped_q) begin
            // tone counter runs before the beat logic
            if (tone_count_q == tone_period_q) begin
              wave_d       = !wave_q;
              tone_count_d = '0;
            end else begin
              tone_count_d = tone_count_q + 1'b1;
            end
            if (presc_q == PresLast) begin
              presc_d = '0;
              if (beat_q == beat_limit_q) begin
                beat_d = '0;
                rd_req = 1'b1;
              end else begin
                beat_d = beat_q + 1'b1;
              end
            end else begin
              presc_d = presc_q + 1'b1;
            end
          end
        end
        OpWrite: begin
          if (in_i.entry_address == '0) begin
            entry0_d = in_i.entry_value;
          end
        end
        OpStart: begin
          note_index_d = '0;
          tone_count_d = '0;
          wave_d       = 1'b0;
          presc_d      = '0;
          beat_d       = '0;
          stopped_d    = 1'b0;
          rd_req       = 1'b1;
        end
        default: ;
      endcase
    end

    if (pending_q && out_free) begin
      drive_d = 1'b1;
      if (ram_rdata > CodeHaltAlt) begin
        tone_period_d = ram_rdata;
        note_index_d  = (note_index_q == IdxLast) ? '0 : note_index_q + 1'b1;
      end else if (ram_rdata == CodeRest) begin
        drive_d      = 1'b0;
        note_index_d = (note_index_q == IdxLast) ? '0 : note_index_q + 1'b1;
      end else if (ram_rdata == CodeRepeat) begin
        tone_period_d = entry0_q;
        note_index_d  = IdxW'(1);
      end else begin
        // halt codes keep the index where it stands
        stopped_d = 1'b1;
        drive_d   = 1'b0;
      end
    end
  end

  // result is taken from the updated state, either at once or after the note read
  assign out_load = (fire && !rd_req) || (pending_q && out_free);

  always_comb begin
    pending_d = pending_q;
    if (fire && rd_req) begin
      pending_d = 1'b1;
    end else if (pending_q && out_free) begin
      pending_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      note_index_q  <= '0;
      tone_period_q <= '0;
      tone_count_q  <= '0;
      wave_q        <= 1'b0;
      presc_q       <= '0;
      beat_q        <= '0;
      drive_q       <= 1'b0;
      stopped_q     <= 1'b1;
      pending_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      note_index_q  <= note_index_d;
      tone_period_q <= tone_period_d;
      tone_count_q  <= tone_count_d;
      wave_q        <= wave_d;
      presc_q       <= presc_d;
      beat_q        <= beat_d;
      drive_q       <= drive_d;
      stopped_q     <= stopped_d;
      pending_q     <= pending_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    entry0_q <= entry0_d;
    if (out_load) begin
      out_level_q  <= drive_d && wave_d;
      out_driven_q <= drive_d;
      out_pos_q    <= PositionW'(note_index_d);
      out_halted_q <= stopped_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.speaker_level  = out_level_q;
  assign out_o.speaker_driven = out_driven_q;
  assign out_o.note_position  = out_pos_q;
  assign out_o.halted         = out_halted_q;

`ifndef SYNTHESIS
  // interlock: no word accepted while a note read resolves
  assert property (@(posedge clk_i) disable iff (!rst_ni) pending_q |-> !in_i.ready)
    else $error("word accepted during pending note read");

  // a resolved note read always leaves a result word behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q && out_free |=> !pending_q && out_o.valid)
    else $error("note read resolved without a result word");

  // a halted sequencer ignores ticks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (op == OpTick) && stopped_q |=> $stable(tone_count_q) && $stable(presc_q))
    else $error("counters moved while halted");

  // halted implies the speaker is not driven
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.halted |-> !out_o.speaker_driven)
    else $error("speaker driven while halted");
`endif

endmodule
